@@ hw/rtl/mrrc_pkg.sv @@
// ----------------------------------------------------------------------------
// mrrc_pkg
// Shared types, codes and the byte-wide CRC-16 step for the Modbus RTU
// read-holding-register request/response checker.
// ----------------------------------------------------------------------------
package mrrc_pkg;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_RXBYTE = 2'd1,
    OP_RXEND  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_BAD = 2'd1,
    ST_SHORT   = 2'd2
  } status_e;

  localparam logic KIND_TX      = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
  localparam logic [7:0]  QTY_HI          = 8'h00;
  localparam logic [7:0]  QTY_LO          = 8'h01;

  // frame byte positions
  localparam logic [2:0] POS_ID      = 3'd0;
  localparam logic [2:0] POS_FN      = 3'd1;
  localparam logic [2:0] POS_ADDR_HI = 3'd2;
  localparam logic [2:0] POS_ADDR_LO = 3'd3;
  localparam logic [2:0] POS_QTY_HI  = 3'd4;
  localparam logic [2:0] POS_QTY_LO  = 3'd5;
  localparam logic [2:0] POS_CRC_LO  = 3'd6;
  localparam logic [2:0] POS_CRC_HI  = 3'd7;

  // response byte count before the CRC bytes
  localparam logic [2:0] RX_CRC_LO_POS = 3'd5;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       last;
  } tx_t;

  typedef struct packed {
    logic start;
    logic rx_byte;
    logic rx_end;
  } rx_cmd_t;

  typedef struct packed {
    logic    vld;
    status_e status;
  } verdict_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/mrrc_frame_gen.sv @@
// ----------------------------------------------------------------------------
// mrrc_frame_gen
// Emits the 8-byte read request frame, one byte per cycle while advance_i is high,
// folding the CRC over the first six bytes as they go out.
// ----------------------------------------------------------------------------
module mrrc_frame_gen (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [7:0]          id_i,
  input  logic [15:0]         addr_i,
  input  logic                advance_i,
  output logic                busy_o,
  output mrrc_pkg::tx_t       tx_o
);
  import mrrc_pkg::*;

  logic        busy_q, busy_d;
  logic [2:0]  idx_q, idx_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] addr_q, addr_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  cur_byte;
  logic        emit;

  always_comb begin
    case (idx_q)
      POS_ID:      cur_byte = id_q;
      POS_FN:      cur_byte = FN_READ_HOLDING;
      POS_ADDR_HI: cur_byte = addr_q[15:8];
      POS_ADDR_LO: cur_byte = addr_q[7:0];
      POS_QTY_HI:  cur_byte = QTY_HI;
      POS_QTY_LO:  cur_byte = QTY_LO;
      POS_CRC_LO:  cur_byte = crc_q[7:0];
      POS_CRC_HI:  cur_byte = crc_q[15:8];
      default:     cur_byte = 8'h00;
    endcase
  end

  assign emit = busy_q && advance_i;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    id_d   = id_q;
    addr_d = addr_q;
    crc_d  = crc_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = POS_ID;
      id_d   = id_i;
      addr_d = addr_i;
      crc_d  = CRC_INIT;
    end else if (emit) begin
      idx_d = idx_q + 3'd1;
      if (idx_q < POS_CRC_LO) begin
        crc_d = crc_feed(crc_q, cur_byte);
      end
      if (idx_q == POS_CRC_HI) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= POS_ID;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    addr_q <= addr_d;
    crc_q  <= crc_d;
  end

  assign busy_o    = busy_q;
  assign tx_o.vld  = emit;
  assign tx_o.data = cur_byte;
  assign tx_o.last = (idx_q == POS_CRC_HI);

endmodule

@@ hw/rtl/mrrc_rx_check.sv @@
// ----------------------------------------------------------------------------
// mrrc_rx_check
// Tracks the response: running CRC over the first five bytes, compares the
// two CRC bytes, and gives an ok, CRC mismatch or short-response verdict.
// ----------------------------------------------------------------------------
module mrrc_rx_check (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mrrc_pkg::rx_cmd_t   cmd_i,
  input  logic [7:0]          rx_byte_i,
  output mrrc_pkg::verdict_t  verdict_o
);
  import mrrc_pkg::*;

  logic        awaiting_q, awaiting_d;
  logic [2:0]  count_q, count_d;
  logic [15:0] crc_q, crc_d;
  logic        low_match_q, low_match_d;

  always_comb begin
    awaiting_d  = awaiting_q;
    count_d     = count_q;
    crc_d       = crc_q;
    low_match_d = low_match_q;
    verdict_o.vld    = 1'b0;
    verdict_o.status = ST_OK;
    if (cmd_i.start) begin
      awaiting_d  = 1'b1;
      count_d     = 3'd0;
      crc_d       = CRC_INIT;
      low_match_d = 1'b0;
    end else if (cmd_i.rx_byte && awaiting_q) begin
      if (count_q < RX_CRC_LO_POS) begin
        crc_d   = crc_feed(crc_q, rx_byte_i);
        count_d = count_q + 3'd1;
      end else if (count_q == RX_CRC_LO_POS) begin
        low_match_d = (rx_byte_i == crc_q[7:0]);
        count_d     = count_q + 3'd1;
      end else begin
        verdict_o.vld    = 1'b1;
        verdict_o.status = (low_match_q && (rx_byte_i == crc_q[15:8])) ? ST_OK : ST_CRC_BAD;
        awaiting_d       = 1'b0;
      end
    end else if (cmd_i.rx_end && awaiting_q) begin
      verdict_o.vld    = 1'b1;
      verdict_o.status = ST_SHORT;
      awaiting_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q  <= 1'b0;
      count_q     <= 3'd0;
      crc_q       <= CRC_INIT;
      low_match_q <= 1'b0;
    end else begin
      awaiting_q  <= awaiting_d;
      count_q     <= count_d;
      crc_q       <= crc_d;
      low_match_q <= low_match_d;
    end
  end

endmodule

@@ hw/rtl/modbus_rtu_read_request_checker.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_read_request_checker
// Modbus RTU master side of one Read Holding Registers transaction:
// builds the request frame and checks the response CRC.
//
//   channel | dir | handshake              | payload
//   in      | in  | in_valid_i/in_ready_o  | operation, slave_id, register_address, rx_byte
//   out     | out | out_valid_o/out_ready_i| kind, tx_byte, last, status
//
// Received bytes and end-of-reception items are checked as they leave the input
// register; a verdict is loaded into the output register as its transaction leaves.
// After a start is taken, the next transaction waits in the input register while
// the frame generator sends the eight bytes, one per cycle while out_free is high.
// Input register and output register part the channels; while a result is held
// the input register still takes one transaction. Reset clears all control state.
// ----------------------------------------------------------------------------
module modbus_rtu_read_request_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  slave_id_i,
  input  logic [15:0] register_address_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic [1:0]  status_o
);
  import mrrc_pkg::*;

  logic        in_vld_q, in_vld_d;
  logic [1:0]  op_q, op_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  rx_q, rx_d;

  logic        out_vld_q, out_vld_d;
  logic        kind_q, kind_d;
  logic [7:0]  tx_q, tx_d;
  logic        last_q, last_d;
  logic [1:0]  status_q, status_d;

  logic        out_free;
  logic        frm_busy;
  logic        consume;
  tx_t         frm_tx;
  rx_cmd_t     cmd;
  verdict_t    verdict;

  assign out_free   = !out_vld_q || out_ready_i;
  assign consume    = in_vld_q && !frm_busy && out_free;
  assign in_ready_o = !in_vld_q || consume;

  always_comb begin
    cmd = '0;
    if (consume) begin
      case (op_e'(op_q))
        OP_START:  cmd.start   = 1'b1;
        OP_RXBYTE: cmd.rx_byte = 1'b1;
        OP_RXEND:  cmd.rx_end  = 1'b1;
        default:   cmd = '0;
      endcase
    end
  end

  mrrc_frame_gen u_frame_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd.start),
    .id_i      (id_q),
    .addr_i    (addr_q),
    .advance_i (out_free),
    .busy_o    (frm_busy),
    .tx_o      (frm_tx)
  );

  mrrc_rx_check u_rx_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rx_byte_i (rx_q),
    .verdict_o (verdict)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    op_d     = op_q;
    id_d     = id_q;
    addr_d   = addr_q;
    rx_d     = rx_q;
    if (in_ready_o) begin
      in_vld_d = in_valid_i;
      op_d     = operation_i;
      id_d     = slave_id_i;
      addr_d   = register_address_i;
      rx_d     = rx_byte_i;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    kind_d    = kind_q;
    tx_d      = tx_q;
    last_d    = last_q;
    status_d  = status_q;
    if (frm_tx.vld) begin
      out_vld_d = 1'b1;
      kind_d    = KIND_TX;
      tx_d      = frm_tx.data;
      last_d    = frm_tx.last;
      status_d  = ST_OK;
    end else if (verdict.vld) begin
      out_vld_d = 1'b1;
      kind_d    = KIND_VERDICT;
      tx_d      = 8'h00;
      last_d    = 1'b1;
      status_d  = verdict.status;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    id_q     <= id_d;
    addr_q   <= addr_d;
    rx_q     <= rx_d;
    kind_q   <= kind_d;
    tx_q     <= tx_d;
    last_q   <= last_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_vld_q;
  assign kind_o      = kind_q;
  assign tx_byte_o   = tx_q;
  assign last_o      = last_q;
  assign status_o    = status_q;

endmodule
